// ===== hdl/awms_pkg.sv =====
`default_nettype none
package awms_pkg;

  localparam int MaxWindow  = 64;
  localparam int AddrW      = $clog2(MaxWindow);
  localparam int CntW       = AddrW + 1;
  localparam int HalfWidth  = 2;
  localparam int Taps       = 2 * HalfWidth + 1;
  localparam int TapW       = $clog2(Taps + 1);
  localparam int IdxW       = CntW + 2;
  localparam int SqW        = 32;
  localparam int RadW       = 40;
  localparam int RootW      = RadW / 2;
  localparam int SqrtCntW   = $clog2(RootW);
  localparam int MagW       = 21;
  localparam int SumW       = MagW + AddrW;
  localparam int AccW       = MagW + 2 + TapW;
  localparam int DivW       = SumW;
  localparam int DvsW       = CntW;
  localparam int DivCntW    = $clog2(DivW);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SQI, S_SQRT, S_STORE, S_MDIV_GO, S_MDIV,
    S_TAP_RD, S_TAP_ACC, S_ADIV_GO, S_ADIV, S_OUT
  } awms_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sqrt_init;
    logic sqrt_step;
    logic store;
    logic mdiv_start;
    logic mean_cap;
    logic tap_rd;
    logic tap_acc;
    logic adiv_start;
    logic out_load;
    logic next;
  } awms_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic sqrt_last;
    logic win_last;
    logic div_done;
    logic tap_last;
    logic out_taken;
    logic i_last;
  } awms_stat_t;

endpackage
`default_nettype wire

// ===== hdl/awms_div.sv =====
`default_nettype none
module awms_div
  import awms_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [DivW-1:0] dividend,
  input  wire logic [DvsW-1:0] divisor,
  output logic                 done,
  output logic [DivW-1:0]      quotient
);

  logic               busy_r;
  logic               done_r;
  logic [DivCntW-1:0] cnt_r;
  logic [DivW-1:0]    quo_r;
  logic [DvsW-1:0]    rem_r;
  logic [DvsW-1:0]    dvs_r;
  logic [DvsW:0]      rem_sh;
  logic               ge;
  logic [DvsW-1:0]    rem_nxt;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DivW-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? DvsW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DvsW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DivW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== hdl/awms_ctrl.sv =====
`default_nettype none
module awms_ctrl
  import awms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire awms_stat_t stat,
  output awms_cmd_t       cmd
);

  awms_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_MUL;
      S_MUL:     if (stat.mul_last) state_nxt = S_SQI;
      S_SQI:     state_nxt = S_SQRT;
      S_SQRT:    if (stat.sqrt_last) state_nxt = S_STORE;
      S_STORE:   state_nxt = stat.win_last ? S_MDIV_GO : S_IDLE;
      S_MDIV_GO: state_nxt = S_MDIV;
      S_MDIV:    if (stat.div_done) state_nxt = S_TAP_RD;
      S_TAP_RD:  state_nxt = S_TAP_ACC;
      S_TAP_ACC: state_nxt = stat.tap_last ? S_ADIV_GO : S_TAP_RD;
      S_ADIV_GO: state_nxt = S_ADIV;
      S_ADIV:    if (stat.div_done) state_nxt = S_OUT;
      S_OUT:     if (stat.out_taken) state_nxt = stat.i_last ? S_IDLE : S_TAP_RD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_MUL:     cmd.mul        = 1'b1;
      S_SQI:     cmd.sqrt_init  = 1'b1;
      S_SQRT:    cmd.sqrt_step  = 1'b1;
      S_STORE:   cmd.store      = 1'b1;
      S_MDIV_GO: cmd.mdiv_start = 1'b1;
      S_MDIV:    cmd.mean_cap   = stat.div_done;
      S_TAP_RD:  cmd.tap_rd     = 1'b1;
      S_TAP_ACC: cmd.tap_acc    = 1'b1;
      S_ADIV_GO: cmd.adiv_start = 1'b1;
      S_ADIV:    cmd.out_load   = stat.div_done;
      S_OUT:     cmd.next       = stat.out_taken;
      default:   cmd            = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/awms_dp.sv =====
`default_nettype none
module awms_dp
  import awms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire awms_cmd_t   cmd,
  output awms_stat_t       stat,
  input  wire logic [15:0] in_x,
  input  wire logic [15:0] in_y,
  input  wire logic [15:0] in_z,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [MagW-1:0]  out_value,
  output logic [AddrW-1:0] out_index,
  output logic             out_last
);

  logic signed [15:0] x_r, y_r, z_r;
  logic               last_r;
  logic [1:0]         mcnt_r;
  logic [SqW-1:0]     prod_r;
  logic [SqW-1:0]     sq_r;
  logic signed [15:0] msel;
  logic signed [SqW-1:0] msq;

  logic [RadW-1:0]     rad_r;
  logic [RootW+1:0]    rem_r;
  logic [RootW-1:0]    root_r;
  logic [SqrtCntW-1:0] scnt_r;
  logic [RootW+3:0]    rem_sh;
  logic [RootW+3:0]    trial;
  logic                sq_ge;

  logic [MagW-1:0]  mem [MaxWindow];
  logic [MagW-1:0]  mem_q_r;
  logic [CntW-1:0]  cnt_r;
  logic [SumW-1:0]  sum_r;
  logic [MagW-1:0]  mean_r;

  logic [AddrW-1:0]       i_r;
  logic [TapW-1:0]        k_r;
  logic [TapW-1:0]        tcnt_r;
  logic                   tvalid_r;
  logic signed [AccW-1:0] acc_r;
  logic signed [IdxW-1:0] j;
  logic                   i_last;
  logic [AccW-1:0]        acc_abs;

  logic            div_start;
  logic [DivW-1:0] div_dvd;
  logic [DvsW-1:0] div_dvs;
  logic            div_done;
  logic [DivW-1:0] div_q;
  logic            out_valid_r;
  logic [MagW-1:0] out_value_r;
  logic [AddrW-1:0] out_index_r;
  logic            out_last_r;

  // Squares of the three axes go through one multiplier, one axis a cycle.
  always_comb begin
    case (mcnt_r)
      2'd0:    msel = x_r;
      2'd1:    msel = y_r;
      2'd2:    msel = z_r;
      default: msel = '0;
    endcase
    msq = msel * msel;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_x;
      y_r     <= in_y;
      z_r     <= in_z;
      last_r  <= in_last;
      mcnt_r  <= '0;
      prod_r  <= '0;
      sq_r    <= '0;
    end else if (cmd.mul) begin
      prod_r <= SqW'(msq);
      sq_r   <= sq_r + prod_r;
      mcnt_r <= mcnt_r + 1'b1;
    end
  end

  // Digit-by-digit square root, two radicand bits per step.
  always_comb begin
    rem_sh = {rem_r, rad_r[RadW-1:RadW-2]};
    trial  = {2'b00, root_r, 2'b01};
    sq_ge  = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad_r  <= {sq_r, 8'h00};
      rem_r  <= '0;
      root_r <= '0;
      scnt_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[RadW-3:0], 2'b00};
      rem_r  <= sq_ge ? (RootW+2)'(rem_sh - trial) : rem_sh[RootW+1:0];
      root_r <= {root_r[RootW-2:0], sq_ge};
      scnt_r <= scnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && (cnt_r < CntW'(MaxWindow))) begin
      mem[cnt_r[AddrW-1:0]] <= MagW'(root_r);
    end
    if (cmd.tap_rd) begin
      mem_q_r <= mem[j[AddrW-1:0]];
    end
  end

  assign j      = $signed({3'b000, i_r}) - IdxW'(HalfWidth) + $signed({{(IdxW-TapW){1'b0}}, k_r});
  assign i_last = ({1'b0, i_r} == (cnt_r - 1'b1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else if (cmd.store && (cnt_r < CntW'(MaxWindow))) begin
      cnt_r <= cnt_r + 1'b1;
      sum_r <= sum_r + SumW'(root_r);
    end else if (cmd.next && i_last) begin
      cnt_r <= '0;
      sum_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_cap) begin
      mean_r <= div_q[MagW-1:0];
      i_r    <= '0;
      k_r    <= '0;
      tcnt_r <= '0;
      acc_r  <= '0;
    end else if (cmd.next) begin
      i_r    <= i_r + 1'b1;
      k_r    <= '0;
      tcnt_r <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.tap_rd) begin
        tvalid_r <= (j >= 0) && (j < $signed({2'b00, cnt_r}));
      end
      if (cmd.tap_acc) begin
        k_r <= k_r + 1'b1;
        if (tvalid_r) begin
          acc_r  <= acc_r + $signed(AccW'(mem_q_r)) - $signed(AccW'(mean_r));
          tcnt_r <= tcnt_r + 1'b1;
        end
      end
    end
  end

  assign acc_abs   = acc_r[AccW-1] ? AccW'(-acc_r) : AccW'(acc_r);
  assign div_start = cmd.mdiv_start | cmd.adiv_start;
  assign div_dvd   = cmd.mdiv_start ? sum_r : DivW'(acc_abs);
  assign div_dvs   = cmd.mdiv_start ? cnt_r : DvsW'(tcnt_r);

  awms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The quotient is a magnitude; the sign of the sum is put back afterwards.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= acc_r[AccW-1] ? MagW'(-div_q[MagW-1:0]) : div_q[MagW-1:0];
      out_index_r <= i_r;
      out_last_r  <= i_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;

  assign stat.mul_last  = (mcnt_r == 2'd3);
  assign stat.sqrt_last = (scnt_r == SqrtCntW'(RootW - 1));
  assign stat.win_last  = last_r;
  assign stat.div_done  = div_done;
  assign stat.tap_last  = (k_r == TapW'(Taps - 1));
  assign stat.out_taken = out_valid_r & out_ready;
  assign stat.i_last    = i_last;

endmodule
`default_nettype wire

// ===== hdl/accel_window_magnitude_smoother.sv =====
// Accelerometer window magnitude smoother.
// Input stream: one three-axis sample per request; in_tlast closes the window.
// Each sample is squared axis by axis on one multiplier, passed through a
// 20-step square root and written to the window memory; in_tready stays low
// from acceptance until the sample has been stored, so the block takes no
// new sample before it is through with the last one.
// A sample that arrives once 64 are stored is dropped, but its tlast still
// closes the window.
// After the closing sample the shared divider forms the window mean in 27
// quotient steps. Each result then reads its five neighbor slots, each with
// a read step and an accumulate step, and goes through the same divider.
// Results leave one at a time through an output register; while the receiver
// holds out_tready low the block waits with the result in place. No new
// sample is taken until the last result of the window has been delivered.
// Reset clears the control state, the sample count and running sum, and the
// output valid flag.
`default_nettype none
module accel_window_magnitude_smoother
  import awms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // filtered_value[20:0], sample_index[26:21], zero
  output logic             out_tlast
);

  awms_cmd_t        cmd;
  awms_stat_t       stat;
  logic [MagW-1:0]  value;
  logic [AddrW-1:0] index;

  awms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  awms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_x      (in_tdata[15:0]),
    .in_y      (in_tdata[31:16]),
    .in_z      (in_tdata[47:32]),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (value),
    .out_index (index),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'b00000, index, value};

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("second sample taken too early");

  a_idle_after_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not idle after final result");

endmodule
`default_nettype wire
